// ===== sv/elfm_pkg.sv =====
`default_nettype none

package elfm_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 16;

    localparam logic [3:0]  STATUS_LEN  = 4'd8;
    localparam logic [7:0]  RUN_MAX     = 8'hFF;
    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_STATUS_ID  = 3'd0,
        CFG_FAULT_RUN  = 3'd1,
        CFG_RECOV_RUN  = 3'd2,
        CFG_TIMEOUT_MS = 3'd3,
        CFG_TICK_MS    = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        KIND_FRAME = 1'b0,
        KIND_TICK  = 1'b1
    } t_kind;

    typedef struct packed {
        logic [10:0] status_frame_id;
        logic [7:0]  fault_run_limit;
        logic [7:0]  recover_run_limit;
        logic [15:0] timeout_ms;
        logic [9:0]  tick_ms;
    } t_cfg;

    typedef struct packed {
        logic               cmd;
        logic [10:0]        frame_id;
        logic [3:0]         frame_len;
        logic [7:0]         rx_byte0;
        logic [7:0]         rx_byte1;
        logic [7:0]         rx_byte2;
        logic [7:0]         rx_byte3;
        logic [7:0]         rx_byte4;
        logic signed [15:0] throttle;
        logic [7:0]         direction;
        logic [7:0]         enable;
    } t_item;

    typedef struct packed {
        logic               tx_valid;
        logic [7:0]         tx_throttle_high;
        logic [7:0]         tx_throttle_low;
        logic [7:0]         tx_direction;
        logic [7:0]         tx_enable;
        logic               frame_accepted;
        logic [15:0]        speed_rpm;
        logic signed [15:0] current_tenths;
        logic [7:0]         fault_code_out;
        logic               fault_flag;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/elfm_in_if.sv =====
`default_nettype none

interface elfm_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [10:0]        frame_id;
    logic [3:0]         frame_len;
    logic [7:0]         rx_byte0;
    logic [7:0]         rx_byte1;
    logic [7:0]         rx_byte2;
    logic [7:0]         rx_byte3;
    logic [7:0]         rx_byte4;
    logic signed [15:0] throttle;
    logic [7:0]         direction;
    logic [7:0]         enable;

    modport source (
        output valid, cmd, frame_id, frame_len, rx_byte0, rx_byte1, rx_byte2,
               rx_byte3, rx_byte4, throttle, direction, enable,
        input  ready
    );

    modport sink (
        input  valid, cmd, frame_id, frame_len, rx_byte0, rx_byte1, rx_byte2,
               rx_byte3, rx_byte4, throttle, direction, enable,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/elfm_out_if.sv =====
`default_nettype none

interface elfm_out_if;
    logic               valid;
    logic               ready;
    logic               tx_valid;
    logic [7:0]         tx_throttle_high;
    logic [7:0]         tx_throttle_low;
    logic [7:0]         tx_direction;
    logic [7:0]         tx_enable;
    logic               frame_accepted;
    logic [15:0]        speed_rpm;
    logic signed [15:0] current_tenths;
    logic [7:0]         fault_code_out;
    logic               fault_flag;

    modport source (
        output valid, tx_valid, tx_throttle_high, tx_throttle_low, tx_direction,
               tx_enable, frame_accepted, speed_rpm, current_tenths,
               fault_code_out, fault_flag,
        input  ready
    );

    modport sink (
        input  valid, tx_valid, tx_throttle_high, tx_throttle_low, tx_direction,
               tx_enable, frame_accepted, speed_rpm, current_tenths,
               fault_code_out, fault_flag,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/elfm_cfg_regs.sv =====
`default_nettype none

module elfm_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [elfm_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [elfm_pkg::CfgDataW-1:0] i_cfg_data,
    output elfm_pkg::t_cfg                     o_cfg
);
    import elfm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.status_frame_id   <= 11'd0;
            r_cfg.fault_run_limit   <= 8'd3;
            r_cfg.recover_run_limit <= 8'd3;
            r_cfg.timeout_ms        <= 16'd500;
            r_cfg.tick_ms           <= 10'd10;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_STATUS_ID:  r_cfg.status_frame_id   <= i_cfg_data[10:0];
                CFG_FAULT_RUN:  r_cfg.fault_run_limit   <= i_cfg_data[7:0];
                CFG_RECOV_RUN:  r_cfg.recover_run_limit <= i_cfg_data[7:0];
                CFG_TIMEOUT_MS: r_cfg.timeout_ms        <= i_cfg_data[15:0];
                CFG_TICK_MS:    r_cfg.tick_ms           <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/elfm_core.sv =====
`default_nettype none

module elfm_core (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire elfm_pkg::t_cfg i_cfg,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire elfm_pkg::t_item i_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output elfm_pkg::t_result o_result
);
    import elfm_pkg::*;

    logic    r_in_vld;
    t_item   r_in;
    logic    r_out_vld;
    t_result r_out;

    logic [15:0] r_speed, n_speed;
    logic [15:0] r_current, n_current;
    logic [7:0]  r_code, n_code;
    logic        r_fault, n_fault;
    logic [7:0]  r_fault_run, n_fault_run;
    logic [7:0]  r_healthy_run, n_healthy_run;
    logic [16:0] r_elapsed, n_elapsed;
    logic        r_seen, n_seen;
    logic        r_pending, n_pending;

    logic        w_adv;
    logic        w_is_tick;
    logic        w_match;
    logic [17:0] w_sum;
    t_result     n_out;

    // one beat moves from the input register to the result register
    assign w_adv      = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv;
    assign w_is_tick  = (t_kind'(r_in.cmd) == KIND_TICK);
    assign w_match    = !w_is_tick && (r_in.frame_id == i_cfg.status_frame_id)
                        && (r_in.frame_len == STATUS_LEN);
    assign w_sum      = {1'b0, r_elapsed} + 18'(i_cfg.tick_ms);

    always_comb begin
        n_speed       = r_speed;
        n_current     = r_current;
        n_code        = r_code;
        n_fault       = r_fault;
        n_fault_run   = r_fault_run;
        n_healthy_run = r_healthy_run;
        n_elapsed     = r_elapsed;
        n_seen        = r_seen;
        n_pending     = r_pending;
        if (w_match) begin
            n_speed   = {r_in.rx_byte0, r_in.rx_byte1};
            n_current = {r_in.rx_byte2, r_in.rx_byte3};
            n_code    = r_in.rx_byte4;
            n_seen    = 1'b1;
            n_pending = 1'b1;
            if (r_in.rx_byte4 != 8'd0) begin
                n_healthy_run = 8'd0;
                n_fault_run   = (r_fault_run != RUN_MAX) ? r_fault_run + 8'd1 : r_fault_run;
                if (n_fault_run >= i_cfg.fault_run_limit) begin
                    n_fault = 1'b1;
                end
            end else begin
                n_fault_run   = 8'd0;
                n_healthy_run = (r_healthy_run != RUN_MAX) ? r_healthy_run + 8'd1
                                                           : r_healthy_run;
                if (n_healthy_run >= i_cfg.recover_run_limit) begin
                    n_fault = 1'b0;
                end
            end
        end else if (w_is_tick) begin
            // a pending status restarts the timer at this tick
            if (r_pending) begin
                n_elapsed = 17'd0;
                n_pending = 1'b0;
            end else if (w_sum > {1'b0, ELAPSED_MAX}) begin
                n_elapsed = ELAPSED_MAX;
            end else begin
                n_elapsed = w_sum[16:0];
            end
            if (r_seen && (n_elapsed > {1'b0, i_cfg.timeout_ms})) begin
                n_fault = 1'b1;
            end
        end
    end

    always_comb begin
        n_out                  = '0;
        n_out.tx_valid         = w_is_tick;
        if (w_is_tick) begin
            n_out.tx_throttle_high = r_in.throttle[15:8];
            n_out.tx_throttle_low  = r_in.throttle[7:0];
            n_out.tx_direction     = r_in.direction;
            n_out.tx_enable        = r_in.enable;
        end
        n_out.frame_accepted   = w_match;
        n_out.speed_rpm        = n_speed;
        n_out.current_tenths   = n_current;
        n_out.fault_code_out   = n_code;
        n_out.fault_flag       = n_fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_speed       <= 16'd0;
            r_current     <= 16'd0;
            r_code        <= 8'd0;
            r_fault       <= 1'b0;
            r_fault_run   <= 8'd0;
            r_healthy_run <= 8'd0;
            r_elapsed     <= 17'd0;
            r_seen        <= 1'b0;
            r_pending     <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (w_adv) begin
                r_out_vld     <= 1'b1;
                r_speed       <= n_speed;
                r_current     <= n_current;
                r_code        <= n_code;
                r_fault       <= n_fault;
                r_fault_run   <= n_fault_run;
                r_healthy_run <= n_healthy_run;
                r_elapsed     <= n_elapsed;
                r_seen        <= n_seen;
                r_pending     <= n_pending;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_item;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

endmodule

`default_nettype wire

// ===== sv/esc_link_fault_monitor.sv =====
// Channel   Dir   Beat content
// i_in      in    received frame (cmd 0) or heartbeat tick (cmd 1)
// o_out     out   command bytes on tick, decoded status, fault flag
// i_cfg_*   in    register write: index, 16-bit data
//
// One beat per cycle sustained while the output is not stalled; a beat passes the
// input register, then the result register after the state update, and output
// valid rises when the beat reaches the result register.
// Reset is synchronous, active low: counters, timer and flags clear, registers
// take their defaults. A stalled output holds its beat; one more input beat is
// taken into the input register and then input ready drops.
`default_nettype none

module esc_link_fault_monitor (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    elfm_in_if.sink                            i_in,
    elfm_out_if.source                         o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [elfm_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [elfm_pkg::CfgDataW-1:0] i_cfg_data
);
    import elfm_pkg::*;

    t_cfg    w_cfg;
    t_item   w_item;
    t_result w_result;
    logic    w_in_ready;
    logic    w_out_valid;

    assign w_item.cmd       = i_in.cmd;
    assign w_item.frame_id  = i_in.frame_id;
    assign w_item.frame_len = i_in.frame_len;
    assign w_item.rx_byte0  = i_in.rx_byte0;
    assign w_item.rx_byte1  = i_in.rx_byte1;
    assign w_item.rx_byte2  = i_in.rx_byte2;
    assign w_item.rx_byte3  = i_in.rx_byte3;
    assign w_item.rx_byte4  = i_in.rx_byte4;
    assign w_item.throttle  = i_in.throttle;
    assign w_item.direction = i_in.direction;
    assign w_item.enable    = i_in.enable;
    assign i_in.ready       = w_in_ready;

    elfm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    elfm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .i_item      (w_item),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_result    (w_result)
    );

    assign o_out.valid            = w_out_valid;
    assign o_out.tx_valid         = w_result.tx_valid;
    assign o_out.tx_throttle_high = w_result.tx_throttle_high;
    assign o_out.tx_throttle_low  = w_result.tx_throttle_low;
    assign o_out.tx_direction     = w_result.tx_direction;
    assign o_out.tx_enable        = w_result.tx_enable;
    assign o_out.frame_accepted   = w_result.frame_accepted;
    assign o_out.speed_rpm        = w_result.speed_rpm;
    assign o_out.current_tenths   = w_result.current_tenths;
    assign o_out.fault_code_out   = w_result.fault_code_out;
    assign o_out.fault_flag       = w_result.fault_flag;

endmodule

`default_nettype wire
